// ===== design/fcw_pkg.sv =====
// ----------------------------------------------------------------------------
// fcw_pkg: shared types and constants for the FAT12 cluster chain walker
// Beat layouts, register indexes, divider handshake and table constants.
// ----------------------------------------------------------------------------
package fcw_pkg;

  // Default size of the allocation table store in bytes.
  localparam int unsigned TableBytesDef = 8192;

  // Field widths fixed by the beat layouts.
  localparam int unsigned AddrW     = 13;
  localparam int unsigned ClusterW  = 12;
  localparam int unsigned OffsetW   = 25;
  localparam int unsigned SectorW   = 20;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;

  // Shared divider: dividend and divisor widths, iteration counter width.
  localparam int unsigned DivBits   = OffsetW;
  localparam int unsigned DivisorW  = 16;
  localparam int unsigned DivCntW   = $clog2(DivBits + 1);

  // Cycle search window: width of the hop distance and window counters.
  localparam int unsigned DistW     = 13;

  // FAT12 link values.
  localparam logic [ClusterW-1:0] EndMark   = 12'hFF8;
  localparam logic [15:0]         EntryMask = 16'h0FFF;

  // Action codes of an input beat.
  localparam logic ActWrite = 1'b0;
  localparam logic ActWalk  = 1'b1;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgClusterBytes     = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSectorsPerClust  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgDataStartSector  = 2'd2;

  // Configuration reset values.
  localparam logic [15:0] ClusterBytesRst  = 16'd512;
  localparam logic [7:0]  SectorsPerRst    = 8'd1;
  localparam logic [15:0] DataStartRst     = 16'd33;

  // Input beat.
  typedef struct packed {
    logic                action;
    logic [AddrW-1:0]    table_address;
    logic [7:0]          table_byte;
    logic [ClusterW-1:0] start_cluster;
    logic [OffsetW-1:0]  offset_in_file;
  } in_item_t;

  // Result beat.
  typedef struct packed {
    logic [ClusterW-1:0] found_cluster;
    logic [SectorW-1:0]  sector_address;
    logic                chain_ended;
  } out_item_t;

  // Request to the shared divider.
  typedef struct packed {
    logic                start;
    logic [DivBits-1:0]  dividend;
    logic [DivisorW-1:0] divisor;
  } div_req_t;

  // Response of the shared divider.
  typedef struct packed {
    logic                done;
    logic [DivBits-1:0]  quotient;
    logic [DivisorW-1:0] remainder;
  } div_rsp_t;

endpackage

// ===== design/fcw_divider.sv =====
// ----------------------------------------------------------------------------
// fcw_divider: shared restoring divider
// Produces one quotient bit per cycle; done pulses when quotient and
// remainder are valid. They hold until the next start.
// ----------------------------------------------------------------------------
module fcw_divider (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fcw_pkg::div_req_t  req_i,
  output fcw_pkg::div_rsp_t  rsp_o
);

  logic                              busy_q;
  logic                              done_q;
  logic [fcw_pkg::DivCntW-1:0]       cnt_q;
  logic [fcw_pkg::DivBits-1:0]       work_q, work_d;
  logic [fcw_pkg::DivisorW-1:0]      part_q, part_d;
  logic [fcw_pkg::DivisorW-1:0]      divisor_q;
  logic [fcw_pkg::DivisorW:0]        trial;
  logic                              fits;

  // One restoring step: bring in the next dividend bit and try a subtract.
  always_comb begin
    trial  = {part_q, work_q[fcw_pkg::DivBits-1]};
    fits   = (trial >= {1'b0, divisor_q});
    part_d = fits ? fcw_pkg::DivisorW'(trial - {1'b0, divisor_q})
                  : trial[fcw_pkg::DivisorW-1:0];
    work_d = {work_q[fcw_pkg::DivBits-2:0], fits};
  end

  // Control: iteration counter and completion pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= fcw_pkg::DivCntW'(fcw_pkg::DivBits);
      end else if (busy_q) begin
        cnt_q <= cnt_q - fcw_pkg::DivCntW'(1);
        if (cnt_q == fcw_pkg::DivCntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: operands load on start, then shift once per cycle.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      work_q    <= req_i.dividend;
      part_q    <= '0;
      divisor_q <= req_i.divisor;
    end else if (busy_q) begin
      work_q <= work_d;
      part_q <= part_d;
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = work_q;
  assign rsp_o.remainder = part_q;

endmodule

// ===== design/fcw_table.sv =====
// ----------------------------------------------------------------------------
// fcw_table: allocation table store
// Two byte banks (even and odd addresses) so that both bytes of a 12-bit
// entry come out in one registered read. Bytes beyond the store read as zero.
// ----------------------------------------------------------------------------
module fcw_table #(
  parameter int unsigned TABLE_BYTES = fcw_pkg::TableBytesDef
) (
  input  logic                      clk_i,
  input  logic                      wr_en_i,
  input  logic [fcw_pkg::AddrW-1:0] wr_addr_i,
  input  logic [7:0]                wr_data_i,
  input  logic [fcw_pkg::AddrW-1:0] rd_pos_i,
  output logic [15:0]               rd_word_o
);

  localparam int unsigned BankDepth = (TABLE_BYTES + 1) / 2;
  localparam int unsigned BankAw    = $clog2(BankDepth);
  localparam int unsigned PosW      = fcw_pkg::AddrW + 1;
  localparam logic [PosW-1:0] Limit = PosW'(TABLE_BYTES);

  logic [7:0] mem_even [BankDepth];
  logic [7:0] mem_odd  [BankDepth];

  logic [PosW-1:0]   wr_pos, lo_pos, hi_pos, even_pos, odd_pos;
  logic              wr_ok;
  logic [BankAw-1:0] wr_idx, even_idx, odd_idx;
  logic [7:0]        even_q, odd_q;
  logic              swap_q, lo_ok_q, hi_ok_q;
  logic [7:0]        lo_byte, hi_byte;

  // Address decode: the low byte sits at pos, the high byte at pos + 1.
  always_comb begin
    wr_pos   = {1'b0, wr_addr_i};
    wr_ok    = wr_pos < Limit;
    wr_idx   = wr_pos[BankAw:1];
    lo_pos   = {1'b0, rd_pos_i};
    hi_pos   = lo_pos + PosW'(1);
    even_pos = rd_pos_i[0] ? hi_pos : lo_pos;
    odd_pos  = rd_pos_i[0] ? lo_pos : hi_pos;
    even_idx = even_pos[BankAw:1];
    odd_idx  = odd_pos[BankAw:1];
  end

  // Even bank.
  always_ff @(posedge clk_i) begin
    if (wr_en_i && wr_ok && !wr_addr_i[0]) begin
      mem_even[wr_idx] <= wr_data_i;
    end
    even_q <= mem_even[even_idx];
  end

  // Odd bank.
  always_ff @(posedge clk_i) begin
    if (wr_en_i && wr_ok && wr_addr_i[0]) begin
      mem_odd[wr_idx] <= wr_data_i;
    end
    odd_q <= mem_odd[odd_idx];
  end

  // Lane order and range flags are registered alongside the read data.
  always_ff @(posedge clk_i) begin
    swap_q  <= rd_pos_i[0];
    lo_ok_q <= lo_pos < Limit;
    hi_ok_q <= hi_pos < Limit;
  end

  // Reassemble the little-endian word.
  always_comb begin
    lo_byte   = swap_q ? odd_q  : even_q;
    hi_byte   = swap_q ? even_q : odd_q;
    rd_word_o = {hi_ok_q ? hi_byte : 8'h00, lo_ok_q ? lo_byte : 8'h00};
  end

endmodule

// ===== design/fat12_cluster_chain_walker.sv =====
// Table write beat: taken while the walker is idle, no result.
// Walk beat: the offset is divided by the cluster size, then each hop reads the
// table read port; a looping chain, once found, is folded with a second divide,
// and the sector address is formed last; one walk is in flight at a time.
// Reset restores the configuration defaults; the table store is not cleared.
// ----------------------------------------------------------------------------
// fat12_cluster_chain_walker: FAT12 cluster chain follower
// Fills a local FAT12 table byte by byte and walks cluster chains on request,
// folding looping chains by power-of-two window cycle detection and one
// shared divider.
// ----------------------------------------------------------------------------
module fat12_cluster_chain_walker #(
  parameter int unsigned TABLE_BYTES = fcw_pkg::TableBytesDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  fcw_pkg::in_item_t            in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output fcw_pkg::out_item_t           out_data_o,
  input  logic                         cfg_we_i,
  input  logic [fcw_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [fcw_pkg::CfgDataW-1:0] cfg_data_i
);

  typedef enum logic [2:0] {
    StIdle,
    StDivHops,
    StRead,
    StEval,
    StDivRest,
    StFinish,
    StOut
  } state_e;

  state_e state_q;

  // Configuration registers.
  logic [15:0] cluster_bytes_q;
  logic [7:0]  sectors_per_q;
  logic [15:0] data_start_q;

  // Walk state.
  logic [fcw_pkg::ClusterW-1:0] cur_q, saved_q;
  logic [fcw_pkg::OffsetW-1:0]  rem_q;
  logic [fcw_pkg::DistW-1:0]    dist_q, win_q;
  logic                         looped_q;
  logic [fcw_pkg::SectorW-1:0]  prod_q;

  fcw_pkg::div_req_t  div_req_q;
  fcw_pkg::div_rsp_t  div_rsp;
  logic                out_valid_q;
  fcw_pkg::out_item_t  out_data_q;

  logic                         in_accept, wr_en;
  logic [fcw_pkg::AddrW-1:0]    rd_pos;
  logic [15:0]                  rd_word;
  logic [fcw_pkg::ClusterW-1:0] next_link;
  logic [fcw_pkg::OffsetW-1:0]  rem_dec;
  logic [fcw_pkg::DistW-1:0]    dist_inc;
  logic [fcw_pkg::SectorW-1:0]  diff, prod;
  logic [15:0]                  hop_divisor;
  logic                         cur_ended, out_free;
  logic                         walk_go, fold_go;

  // Handshake and table write decode.
  assign in_stall_o  = (state_q != StIdle);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign wr_en       = in_accept && (in_data_i.action == fcw_pkg::ActWrite);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  // Divider starts: the hop count of a new walk, or the fold of a found loop.
  assign walk_go = in_accept && (in_data_i.action == fcw_pkg::ActWalk)
                   && (in_data_i.start_cluster < fcw_pkg::EndMark);
  assign fold_go = (state_q == StEval) && (next_link < fcw_pkg::EndMark)
                   && (rem_dec != '0) && !looped_q && (next_link == saved_q);

  // Entry position of the current cluster and the link it holds.
  always_comb begin
    rd_pos      = {1'b0, cur_q} + {2'b00, cur_q[fcw_pkg::ClusterW-1:1]};
    next_link   = cur_q[0] ? rd_word[15:4]
                           : fcw_pkg::ClusterW'(rd_word & fcw_pkg::EntryMask);
    rem_dec     = rem_q - fcw_pkg::OffsetW'(1);
    dist_inc    = dist_q + fcw_pkg::DistW'(1);
    hop_divisor = (cluster_bytes_q == 16'd0) ? 16'd1 : cluster_bytes_q;
    cur_ended   = cur_q >= fcw_pkg::EndMark;
    diff        = {8'h00, cur_q} - fcw_pkg::SectorW'(2);
    prod        = fcw_pkg::SectorW'(diff * {12'h000, sectors_per_q});
  end

  fcw_table #(
    .TABLE_BYTES (TABLE_BYTES)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (in_data_i.table_address),
    .wr_data_i (in_data_i.table_byte),
    .rd_pos_i  (rd_pos),
    .rd_word_o (rd_word)
  );

  fcw_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req_q),
    .rsp_o  (div_rsp)
  );

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cluster_bytes_q <= fcw_pkg::ClusterBytesRst;
      sectors_per_q   <= fcw_pkg::SectorsPerRst;
      data_start_q    <= fcw_pkg::DataStartRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        fcw_pkg::CfgClusterBytes:    cluster_bytes_q <= cfg_data_i;
        fcw_pkg::CfgSectorsPerClust: sectors_per_q   <= cfg_data_i[7:0];
        fcw_pkg::CfgDataStartSector: data_start_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Walk sequencer with windowed cycle detection; the output beat register
  // lives here too.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cur_q       <= '0;
      saved_q     <= '0;
      rem_q       <= '0;
      dist_q      <= '0;
      win_q       <= '0;
      looped_q    <= 1'b0;
      prod_q      <= '0;
      div_req_q   <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      div_req_q.start <= walk_go || fold_go;
      if (out_valid_q && !out_stall_i && (state_q != StOut)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_accept && (in_data_i.action == fcw_pkg::ActWalk)) begin
            cur_q <= in_data_i.start_cluster;
            if (in_data_i.start_cluster >= fcw_pkg::EndMark) begin
              state_q <= StFinish;
            end else begin
              div_req_q.dividend <= in_data_i.offset_in_file;
              div_req_q.divisor  <= hop_divisor;
              state_q            <= StDivHops;
            end
          end
        end
        StDivHops: begin
          if (div_rsp.done) begin
            rem_q    <= div_rsp.quotient;
            saved_q  <= cur_q;
            dist_q   <= '0;
            win_q    <= fcw_pkg::DistW'(1);
            looped_q <= 1'b0;
            state_q  <= (div_rsp.quotient == '0) ? StFinish : StRead;
          end
        end
        StRead: begin
          state_q <= StEval;
        end
        StEval: begin
          cur_q <= next_link;
          rem_q <= rem_dec;
          if ((next_link >= fcw_pkg::EndMark) || (rem_dec == '0)) begin
            state_q <= StFinish;
          end else if (!looped_q && (next_link == saved_q)) begin
            // A repeat: fold the remaining hops modulo the cycle length.
            div_req_q.dividend <= rem_dec;
            div_req_q.divisor  <= 16'(dist_inc);
            state_q            <= StDivRest;
          end else begin
            if (!looped_q) begin
              if (dist_inc == win_q) begin
                saved_q <= next_link;
                dist_q  <= '0;
                win_q   <= {win_q[fcw_pkg::DistW-2:0], 1'b0};
              end else begin
                dist_q <= dist_inc;
              end
            end
            state_q <= StRead;
          end
        end
        StDivRest: begin
          if (div_rsp.done) begin
            rem_q    <= {9'd0, div_rsp.remainder};
            looped_q <= 1'b1;
            state_q  <= (div_rsp.remainder == '0) ? StFinish : StRead;
          end
        end
        StFinish: begin
          prod_q  <= prod;
          state_q <= StOut;
        end
        StOut: begin
          if (out_free) begin
            out_valid_q                <= 1'b1;
            out_data_q.found_cluster  <= cur_q;
            out_data_q.chain_ended    <= cur_ended;
            out_data_q.sector_address <= cur_ended ? '0
                                         : prod_q + {4'h0, data_start_q};
            state_q                    <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

endmodule
